// File: rtl/bdes_pkg.sv
// ----------------------------------------------------------------------------
// Button debounce event scan package
// Shared types, codes and defaults for the debounce and event scanner.
// ----------------------------------------------------------------------------
package bdes_pkg;

   localparam int BUTTONS_DEF = 8;
   localparam int PIN_COUNT   = 8;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 16;
   localparam int CNT_W       = 4;
   localparam int TIME_W      = 32;
   localparam int LIM_W       = 16;

   localparam logic [CNT_W-1:0] BUTTONS_RESET  = 4'd8;
   localparam logic [LIM_W-1:0] DEBOUNCE_RESET = 16'd20;
   localparam logic [LIM_W-1:0] LONG_RESET     = 16'd1000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BUTTONS  = 2'd0,
      CSR_DEBOUNCE = 2'd1,
      CSR_LONG     = 2'd2,
      CSR_SPARE    = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      EV_PRESS   = 2'd0,
      EV_RELEASE = 2'd1,
      EV_CLICK   = 2'd2,
      EV_LONG    = 2'd3
   } event_code_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DEB,
      ST_CLICK,
      ST_LONG,
      ST_FLUSH
   } state_type;

   typedef struct packed {
      logic [TIME_W-1:0]    now_ms;
      logic [PIN_COUNT-1:0] raw_pressed;
   } req_payload_type;

   typedef struct packed {
      logic [2:0] button_index;
      logic [1:0] event_code;
      logic       last_event;
   } rsp_payload_type;

   typedef struct packed {
      logic [TIME_W-1:0] minuend;
      logic [TIME_W-1:0] subtrahend;
      logic [LIM_W-1:0]  limit;
   } cmp_op_type;

endpackage

// File: rtl/bdes_elapsed_cmp.sv
// ----------------------------------------------------------------------------
// Elapsed time compare
// Wrapping 32-bit difference of two timestamps, compared against a limit.
// ----------------------------------------------------------------------------
module bdes_elapsed_cmp (
   input  bdes_pkg::cmp_op_type op,
   output logic                 reached
);
   import bdes_pkg::*;

   logic [TIME_W-1:0] elapsed;

   assign elapsed = op.minuend - op.subtrahend;
   assign reached = elapsed >= {{(TIME_W-LIM_W){1'b0}}, op.limit};

endmodule

// File: rtl/button_debounce_event_scan.sv
// ----------------------------------------------------------------------------
// Button debounce event scan
// Debounces up to eight buttons per scan and reports press, release, click
// and long-press events.
// ----------------------------------------------------------------------------
// Usage:
//  - req channel: one transaction per scan, carrying now_ms and raw_pressed.
//    req_stall is high from the accepting edge until every event of that
//    scan has been handed to the rsp register.
//  - rsp channel: one transaction per event (button_index, event_code);
//    last_event marks the final event of a scan. A scan with no events
//    gives no rsp transaction.
//  - csr port: write-only, buttons_in_use / debounce_time / long_press_time
//    at indexes 0 / 1 / 2; write only while the block is idle.
//  - Sequence: a scan visits each button in the debounce state and then the
//    long-press state, with a click state added for each click event. The
//    single elapsed-time compare unit is used twice per button (debounce
//    check, then long-press check). An event moves on to rsp when the
//    following event is taken into the pending slot, or at the end of the scan.
//  - rsp_stall holds the output register; the sequencer waits while a new
//    event finds the pending slot full and the output register full and stalled.
//  - Reset clears all button levels, times and flags and restores the
//    register defaults (8 buttons, 20 ms, 1000 ms).
// ----------------------------------------------------------------------------
module button_debounce_event_scan #(
   parameter int BUTTONS = bdes_pkg::BUTTONS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  bdes_pkg::req_payload_type             req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output bdes_pkg::rsp_payload_type             rsp_data,
   input  logic                                  csr_write,
   input  logic [bdes_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [bdes_pkg::CSR_DATA_W-1:0]       csr_data
);
   import bdes_pkg::*;

   localparam int LIMIT = (BUTTONS < PIN_COUNT) ? BUTTONS : PIN_COUNT;
   localparam int IDX_W = (LIMIT > 1) ? $clog2(LIMIT) : 1;

   state_type            state_ff, state_in;
   logic [IDX_W-1:0]     btn_ff, btn_in;
   logic [CNT_W-1:0]     cnt_ff;
   logic [TIME_W-1:0]    now_ff;
   logic [PIN_COUNT-1:0] pins_ff;

   logic [CNT_W-1:0]     csr_buttons_ff;
   logic [LIM_W-1:0]     csr_debounce_ff;
   logic [LIM_W-1:0]     csr_long_ff;

   logic                 raw_level_ff     [LIMIT];
   logic                 stable_level_ff  [LIMIT];
   logic                 long_reported_ff [LIMIT];
   logic [TIME_W-1:0]    change_time_ff   [LIMIT];
   logic [TIME_W-1:0]    press_time_ff    [LIMIT];

   logic                 pend_valid_ff, pend_valid_in;
   logic [2:0]           pend_idx_ff, pend_idx_in;
   event_code_type       pend_code_ff, pend_code_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_payload_type      rsp_data_ff, rsp_data_in;

   logic                 req_accept;
   logic [CNT_W-1:0]     cnt_sel;
   logic                 raw_bit;
   logic                 raw_chg;
   logic [TIME_W-1:0]    change_sel;
   logic [LIM_W-1:0]     deb_eff;
   logic [LIM_W-1:0]     long_eff;
   cmp_op_type           cmp_op;
   logic                 reached;
   logic                 accept_deb;
   logic                 long_hit;
   logic                 out_free;
   logic                 blocked;
   logic                 last_btn;
   logic                 ev_req;
   event_code_type       ev_code;
   logic                 deb_apply;
   logic                 long_apply;

   assign req_accept = req_valid && (state_ff == ST_IDLE);
   assign req_stall  = (state_ff != ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   assign cnt_sel  = (csr_buttons_ff > CNT_W'(LIMIT)) ? CNT_W'(LIMIT) : csr_buttons_ff;
   assign deb_eff  = (csr_debounce_ff == '0) ? DEBOUNCE_RESET : csr_debounce_ff;
   assign long_eff = (csr_long_ff == '0) ? LONG_RESET : csr_long_ff;

   assign raw_bit    = pins_ff[btn_ff];
   assign raw_chg    = raw_bit != raw_level_ff[btn_ff];
   assign change_sel = raw_chg ? now_ff : change_time_ff[btn_ff];

   always_comb begin
      cmp_op.minuend = now_ff;
      if (state_ff == ST_LONG) begin
         cmp_op.subtrahend = press_time_ff[btn_ff];
         cmp_op.limit      = long_eff;
      end else begin
         cmp_op.subtrahend = change_sel;
         cmp_op.limit      = deb_eff;
      end
   end

   bdes_elapsed_cmp u_cmp (
      .op      (cmp_op),
      .reached (reached)
   );

   assign accept_deb = (raw_bit != stable_level_ff[btn_ff]) && reached;
   assign long_hit   = stable_level_ff[btn_ff] && !long_reported_ff[btn_ff] && reached;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign blocked    = pend_valid_ff && !out_free;
   assign last_btn   = (CNT_W'(btn_ff) + CNT_W'(1)) >= cnt_ff;

   always_comb begin
      state_in      = state_ff;
      btn_in        = btn_ff;
      pend_valid_in = pend_valid_ff;
      pend_idx_in   = pend_idx_ff;
      pend_code_in  = pend_code_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;
      ev_req        = 1'b0;
      ev_code       = EV_PRESS;
      deb_apply     = 1'b0;
      long_apply    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               btn_in   = '0;
               state_in = (cnt_sel == '0) ? ST_FLUSH : ST_DEB;
            end
         end
         ST_DEB: begin
            ev_req  = accept_deb;
            ev_code = raw_bit ? EV_PRESS : EV_RELEASE;
            if (!(ev_req && blocked)) begin
               deb_apply = 1'b1;
               if (accept_deb && !raw_bit && !long_reported_ff[btn_ff]) begin
                  state_in = ST_CLICK;
               end else begin
                  state_in = ST_LONG;
               end
            end
         end
         ST_CLICK: begin
            ev_req  = 1'b1;
            ev_code = EV_CLICK;
            if (!blocked) begin
               state_in = ST_LONG;
            end
         end
         ST_LONG: begin
            ev_req  = long_hit;
            ev_code = EV_LONG;
            if (!(ev_req && blocked)) begin
               long_apply = 1'b1;
               if (last_btn) begin
                  state_in = ST_FLUSH;
               end else begin
                  btn_in   = btn_ff + 1'b1;
                  state_in = ST_DEB;
               end
            end
         end
         ST_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.button_index = pend_idx_ff;
               rsp_data_in.event_code   = pend_code_ff;
               rsp_data_in.last_event   = 1'b1;
               pend_valid_in            = 1'b0;
               state_in                 = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      // advance pending event into the output register when a new one arrives
      if (ev_req && !blocked) begin
         if (pend_valid_ff) begin
            rsp_valid_in             = 1'b1;
            rsp_data_in.button_index = pend_idx_ff;
            rsp_data_in.event_code   = pend_code_ff;
            rsp_data_in.last_event   = 1'b0;
         end
         pend_valid_in = 1'b1;
         pend_idx_in   = 3'(btn_ff);
         pend_code_in  = ev_code;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         btn_ff        <= '0;
         cnt_ff        <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         btn_ff        <= btn_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (req_accept) begin
            cnt_ff <= cnt_sel;
         end
      end
   end

   always_ff @(posedge clock) begin
      pend_idx_ff  <= pend_idx_in;
      pend_code_ff <= pend_code_in;
      rsp_data_ff  <= rsp_data_in;
      if (req_accept) begin
         now_ff  <= req_data.now_ms;
         pins_ff <= req_data.raw_pressed;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_buttons_ff  <= BUTTONS_RESET;
         csr_debounce_ff <= DEBOUNCE_RESET;
         csr_long_ff     <= LONG_RESET;
      end else if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_BUTTONS:  csr_buttons_ff  <= csr_data[CNT_W-1:0];
            CSR_DEBOUNCE: csr_debounce_ff <= csr_data[LIM_W-1:0];
            CSR_LONG:     csr_long_ff     <= csr_data[LIM_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < LIMIT; k++) begin
            raw_level_ff[k]     <= 1'b0;
            stable_level_ff[k]  <= 1'b0;
            long_reported_ff[k] <= 1'b0;
            change_time_ff[k]   <= '0;
            press_time_ff[k]    <= '0;
         end
      end else begin
         if (deb_apply) begin
            if (raw_chg) begin
               raw_level_ff[btn_ff]   <= raw_bit;
               change_time_ff[btn_ff] <= now_ff;
            end
            if (accept_deb) begin
               stable_level_ff[btn_ff] <= raw_bit;
               if (raw_bit) begin
                  press_time_ff[btn_ff]    <= now_ff;
                  long_reported_ff[btn_ff] <= 1'b0;
               end
            end
         end
         if (long_apply && long_hit) begin
            long_reported_ff[btn_ff] <= 1'b1;
         end
      end
   end

`ifndef SYNTHESIS
   a_pend_flushed: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> (state_ff != ST_IDLE))
      else $error("pending event left behind in idle");

   a_scan_start: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_DEB || state_ff == ST_FLUSH))
      else $error("scan did not start after req transaction");

   a_last_ends_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FLUSH && pend_valid_ff && out_free)
      |=> (state_ff == ST_IDLE && !pend_valid_ff && rsp_valid_ff && rsp_data_ff.last_event))
      else $error("final event not closed out correctly");
`endif

endmodule
